// File: hdl/gdr_pkg.sv
// ----------------------------------------------------------------------------
// gdr_pkg
// Shared types, constants and the per-column ray table of the grid raycaster.
// ----------------------------------------------------------------------------
package gdr_pkg;

	localparam int GRID_SIZE     = 8;
	localparam int SCREEN_HEIGHT = 200;
	localparam int COLUMN_COUNT  = 80;
	localparam int PLANE_MAG     = 169;
	localparam int CELL_ONE      = 256;
	localparam int CELL_HALF     = 128;

	localparam int MAP_W    = 64;
	localparam int COL_W    = 7;
	localparam int COLS     = 1 << COL_W;
	localparam int RV_W     = 10;
	localparam int AXIS_W   = 9;
	localparam int ACC_W    = 16;
	localparam int POS_W    = 5;
	localparam int CNT_W    = 4;
	localparam int GUARD_W  = 6;
	localparam int GUARD_MAX = 4 * GRID_SIZE + 8;
	localparam int H_W      = 8;
	localparam int DVD_W    = 10;
	localparam int DVS_W    = 4;
	localparam int DIV_CNT_W = 4;

	localparam logic [MAP_W-1:0] WALL_MAP_RESET = 64'hFF81A1A1858D81FF;
	localparam logic [AXIS_W-1:0] AXIS_ONE = AXIS_W'(CELL_ONE);
	localparam logic [H_W-1:0]   H_MAX    = H_W'(SCREEN_HEIGHT);
	localparam logic [H_W-1:0]   H_MID    = H_W'(SCREEN_HEIGHT / 2);

	// facing codes
	localparam logic [1:0] FACE_NORTH = 2'd0;
	localparam logic [1:0] FACE_EAST  = 2'd1;
	localparam logic [1:0] FACE_SOUTH = 2'd2;
	localparam logic [1:0] FACE_WEST  = 2'd3;

	typedef struct packed {
		logic [2:0]       cell_x;
		logic [2:0]       cell_y;
		logic [1:0]       facing;
		logic [COL_W-1:0] screen_column;
	} req_t;

	typedef struct packed {
		logic [6:0] column_echo;
		logic [6:0] top_row;
		logic [7:0] wall_bottom;
		logic       hit_side;
	} rsp_t;

	// ray set-up handed to the walker
	typedef struct packed {
		logic [2:0]        gx;
		logic [2:0]        gy;
		logic              neg_x;
		logic              neg_y;
		logic [AXIS_W-1:0] ax;
		logic [AXIS_W-1:0] ay;
	} ray_t;

	// walker outcome: side crossed last and cells stepped on that axis
	typedef struct packed {
		logic             side;
		logic [CNT_W-1:0] n;
	} walk_res_t;

	typedef logic [COLS-1:0][RV_W-1:0] rv_tab_t;

	// plane offset per column, worked out at elaboration
	function automatic rv_tab_t build_rv_tab();
		rv_tab_t t;
		int cam;
		int rv;
		for (int i = 0; i < COLS; i++) begin
			cam  = ((2 * i - COLUMN_COUNT) * CELL_ONE) / COLUMN_COUNT;
			rv   = (PLANE_MAG * cam) / CELL_ONE;
			t[i] = RV_W'(rv);
		end
		return t;
	endfunction

	localparam rv_tab_t RV_TAB = build_rv_tab();

endpackage

// File: hdl/grid_dda_raycast_column.sv
// ----------------------------------------------------------------------------
// grid_dda_raycast_column
// Casts one ray per screen column through an 8x8 wall bitmap and returns the
// wall span and hit side for that column.
// ----------------------------------------------------------------------------
// throughput: one item at a time; the walker takes one cell per cycle and
//   the divider one quotient bit per cycle over 10 bits, and the divide is
//   skipped when the height is taken as full
// reset: arst_n clears control and sets wall_map to the bordered room
// ----------------------------------------------------------------------------
module grid_dda_raycast_column (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      req_valid,
	output logic                      req_stall,
	input  gdr_pkg::req_t             req,
	output logic                      rsp_valid,
	input  logic                      rsp_stall,
	output gdr_pkg::rsp_t             rsp,
	input  logic                      cfg_we,
	input  logic [gdr_pkg::MAP_W-1:0] cfg_wdata
);
	import gdr_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_WALK = 4'b0010,
		S_DIV  = 4'b0100,
		S_DONE = 4'b1000
	} state_t;

	state_t state_q;

	logic [MAP_W-1:0]  wall_map_q;
	logic [COL_W-1:0]  col_q;
	logic [AXIS_W-1:0] ax_q, ay_q;
	logic [H_W-1:0]    h_q;
	rsp_t              rsp_q;
	logic              rsp_valid_q;

	logic              accept;
	logic signed [RV_W-1:0] rv;
	logic [AXIS_W-1:0] rv_abs;
	ray_t              ray;
	logic              walk_done;
	walk_res_t         walk_res;
	logic [AXIS_W-1:0] a_sel;
	logic [AXIS_W+H_W-1:0] prod;
	logic [DVS_W:0]    dvs_full;
	logic              div_start;
	logic              div_done;
	logic [DVD_W-1:0]  quot;
	logic              full_h;
	logic              out_free;

	assign accept   = req_valid && !req_stall;
	assign req_stall = state_q != S_IDLE;
	assign out_free = !rsp_valid_q || !rsp_stall;

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			wall_map_q <= WALL_MAP_RESET;
		else if (cfg_we)
			wall_map_q <= cfg_wdata;
	end

	// ray set-up from the column table and the facing
	always_comb begin
		rv     = $signed(RV_TAB[req.screen_column]);
		rv_abs = rv[RV_W-1] ? AXIS_W'(-rv) : AXIS_W'(rv);
		ray.gx = req.cell_x;
		ray.gy = req.cell_y;
		case (req.facing)
			FACE_NORTH: begin
				ray.neg_x = (rv != '0) && !rv[RV_W-1];
				ray.neg_y = 1'b1;
				ray.ax    = rv_abs;
				ray.ay    = AXIS_ONE;
			end
			FACE_SOUTH: begin
				ray.neg_x = rv[RV_W-1];
				ray.neg_y = 1'b0;
				ray.ax    = rv_abs;
				ray.ay    = AXIS_ONE;
			end
			FACE_WEST: begin
				ray.neg_x = 1'b1;
				ray.neg_y = (rv != '0) && !rv[RV_W-1];
				ray.ax    = AXIS_ONE;
				ray.ay    = rv_abs;
			end
			default: begin
				ray.neg_x = 1'b0;
				ray.neg_y = rv[RV_W-1];
				ray.ax    = AXIS_ONE;
				ray.ay    = rv_abs;
			end
		endcase
	end

	gdr_walk u_walk (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (accept),
		.ray      (ray),
		.wall_map (wall_map_q),
		.done     (walk_done),
		.res      (walk_res)
	);

	// height = 200*a / (128*(2n-1)), the /128 is taken off the dividend first
	always_comb begin
		a_sel     = walk_res.side ? ay_q : ax_q;
		prod      = a_sel * H_MAX;
		dvs_full  = {walk_res.n, 1'b0} - 1'b1;
		full_h    = (walk_res.n == '0) || (a_sel == '0);
		div_start = (state_q == S_WALK) && walk_done && !full_h;
	end

	gdr_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (prod[AXIS_W+H_W-1 -: DVD_W]),
		.divisor  (dvs_full[DVS_W-1:0]),
		.done     (div_done),
		.quotient (quot)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else begin
			case (state_q)
				S_IDLE: if (accept) state_q <= S_WALK;
				S_WALK: if (walk_done) state_q <= full_h ? S_DONE : S_DIV;
				S_DIV:  if (div_done) state_q <= S_DONE;
				S_DONE: if (out_free) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// item payload held while it is in flight
	always_ff @(posedge clk) begin
		if (accept) begin
			col_q <= req.screen_column;
			ax_q  <= ray.ax;
			ay_q  <= ray.ay;
		end
		if (state_q == S_WALK && walk_done)
			h_q <= H_MAX;
		else if (state_q == S_DIV && div_done)
			h_q <= (quot > DVD_W'(H_MAX)) ? H_MAX : quot[H_W-1:0];
		if (state_q == S_DONE && out_free) begin
			rsp_q.column_echo <= col_q;
			rsp_q.top_row     <= 7'(H_MID - {1'b0, h_q[H_W-1:1]});
			rsp_q.wall_bottom <= H_MID + {1'b0, h_q[H_W-1:1]};
			rsp_q.hit_side    <= walk_res.side;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			rsp_valid_q <= 1'b0;
		else if (state_q == S_DONE && out_free)
			rsp_valid_q <= 1'b1;
		else if (!rsp_stall)
			rsp_valid_q <= 1'b0;
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

// File: hdl/gdr_walk.sv
// ----------------------------------------------------------------------------
// gdr_walk
// Grid DDA walker: one shared add and compare unit takes one cell step a cycle.
// ----------------------------------------------------------------------------
module gdr_walk (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  gdr_pkg::ray_t             ray,
	input  logic [gdr_pkg::MAP_W-1:0] wall_map,
	output logic                      done,
	output gdr_pkg::walk_res_t        res
);
	import gdr_pkg::*;

	logic                busy_q;
	logic                done_q;
	logic [ACC_W-1:0]    sx_q, sy_q, incx_q, incy_q;
	logic                fx_q, fy_q, negx_q, negy_q;
	logic signed [POS_W-1:0] mx_q, my_q;
	logic [CNT_W-1:0]    nx_q, ny_q;
	logic                side_q;
	logic [GUARD_W-1:0]  guard_q;

	logic             outside;
	logic             hit;
	logic             stop;
	logic             take_x;
	logic [ACC_W-1:0] sum;

	// wall test, cells off the grid count as walls
	always_comb begin
		outside = mx_q[POS_W-1] | mx_q[3] | my_q[POS_W-1] | my_q[3];
		hit     = outside || wall_map[{my_q[2:0], mx_q[2:0]}];
		stop    = hit || (guard_q == GUARD_W'(GUARD_MAX));
	end

	// shared unit: pick the nearer boundary, ties go to y
	always_comb begin
		if (fx_q)
			take_x = 1'b0;
		else if (fy_q)
			take_x = 1'b1;
		else
			take_x = sx_q < sy_q;
		sum = (take_x ? sx_q : sy_q) + (take_x ? incx_q : incy_q);
	end

	// accumulators are scaled by 1/128 of the cross products
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= busy_q && stop;
			if (start)
				busy_q <= 1'b1;
			else if (stop)
				busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			sx_q    <= ACC_W'(ray.ay);
			sy_q    <= ACC_W'(ray.ax);
			incx_q  <= ACC_W'({ray.ay, 1'b0});
			incy_q  <= ACC_W'({ray.ax, 1'b0});
			fx_q    <= ray.ax == '0;
			fy_q    <= ray.ay == '0;
			negx_q  <= ray.neg_x;
			negy_q  <= ray.neg_y;
			mx_q    <= POS_W'(ray.gx);
			my_q    <= POS_W'(ray.gy);
			nx_q    <= '0;
			ny_q    <= '0;
			side_q  <= 1'b0;
			guard_q <= '0;
		end else if (busy_q && !stop) begin
			guard_q <= guard_q + 1'b1;
			if (take_x) begin
				sx_q   <= sum;
				mx_q   <= negx_q ? mx_q - 1'b1 : mx_q + 1'b1;
				nx_q   <= nx_q + 1'b1;
				side_q <= 1'b0;
			end else begin
				sy_q   <= sum;
				my_q   <= negy_q ? my_q - 1'b1 : my_q + 1'b1;
				ny_q   <= ny_q + 1'b1;
				side_q <= 1'b1;
			end
		end
	end

	assign done     = done_q;
	assign res.side = side_q;
	assign res.n    = side_q ? ny_q : nx_q;

endmodule

// File: hdl/gdr_div.sv
// ----------------------------------------------------------------------------
// gdr_div
// Restoring divider, one quotient bit a cycle.
// ----------------------------------------------------------------------------
module gdr_div (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [gdr_pkg::DVD_W-1:0] dividend,
	input  logic [gdr_pkg::DVS_W-1:0] divisor,
	output logic                      done,
	output logic [gdr_pkg::DVD_W-1:0] quotient
);
	import gdr_pkg::*;

	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [DVS_W-1:0]     dvs_q;
	logic [DVS_W-1:0]     rem_q;
	logic [DVD_W-1:0]     dq_q;

	logic [DVS_W:0] shifted;
	logic [DVS_W:0] diff;
	logic           ge;

	// trial subtract
	always_comb begin
		shifted = {rem_q, dq_q[DVD_W-1]};
		diff    = shifted - {1'b0, dvs_q};
		ge      = shifted >= {1'b0, dvs_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == DIV_CNT_W'(1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= DIV_CNT_W'(DVD_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == DIV_CNT_W'(1))
					busy_q <= 1'b0;
			end
		end
	end

	// quotient bits shift in where dividend bits leave
	always_ff @(posedge clk) begin
		if (start) begin
			dvs_q <= divisor;
			rem_q <= '0;
			dq_q  <= dividend;
		end else if (busy_q) begin
			rem_q <= ge ? diff[DVS_W-1:0] : shifted[DVS_W-1:0];
			dq_q  <= {dq_q[DVD_W-2:0], ge};
		end
	end

	assign done     = done_q;
	assign quotient = dq_q;

endmodule

// File: tb/sv/grid_dda_raycast_column_tb.sv
// ----------------------------------------------------------------------------
// grid_dda_raycast_column_tb
// Casts column rays through several wall maps and checks every wall span
// against a typed-in span or a local model of the grid walk and height
// divide. Handshakes on both sides are throttled by random idling, and one
// long output hold-off backs the block up into its input.
// ----------------------------------------------------------------------------
module grid_dda_raycast_column_tb;

	timeunit 1ns;
	timeprecision 1ps;

	import gdr_pkg::*;

	localparam int CYCLE_LIMIT  = 200000;
	localparam int HOLD_CYCLES  = 80;
	localparam int SETTLE_WAIT  = 40;
	localparam int PROBE_COUNT  = 20;

	// one directed row: item, and a typed-in span where it is obvious
	typedef struct {
		req_t stim;
		bit   typed;
		rsp_t want;
	} probe_row_t;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 req_valid;
	logic                 req_stall;
	req_t                 req;
	logic                 rsp_valid;
	logic                 rsp_stall;
	rsp_t                 rsp;
	logic                 cfg_we;
	logic [MAP_W-1:0]     cfg_wdata;

	logic [MAP_W-1:0]     wall_map_now;
	rsp_t                 expected_spans[$];
	int                   send_idle_pct;
	int                   recv_idle_pct;
	bit                   hold_request;
	int                   mismatches;
	int                   items_sent;
	int                   spans_checked;
	int                   map_count;
	int                   cycle_count;

	grid_dda_raycast_column i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	always #5ns clk = ~clk;

	// wall span of one column ray: grid walk, then clamped height
	function automatic rsp_t cast_column(input req_t item, input logic [MAP_W-1:0] map);
		int   gx, gy, col, px, py, cam, rv, rdx, rdy;
		int   mx, my, stepx, stepy, ax, ay, sx, sy, dxs, dys;
		int   perp_dist, h, top, bot;
		bit   side;
		rsp_t span;
		gx  = item.cell_x;
		gy  = item.cell_y;
		col = item.screen_column;
		px  = gx * CELL_ONE + CELL_HALF;
		py  = gy * CELL_ONE + CELL_HALF;
		cam = ((2 * col - COLUMN_COUNT) * CELL_ONE) / COLUMN_COUNT;
		rv  = (PLANE_MAG * cam) / CELL_ONE;
		case (item.facing)
			FACE_NORTH: begin
				rdx = -rv;
				rdy = -CELL_ONE;
			end
			FACE_SOUTH: begin
				rdx = rv;
				rdy = CELL_ONE;
			end
			FACE_WEST: begin
				rdx = -CELL_ONE;
				rdy = -rv;
			end
			default: begin
				rdx = CELL_ONE;
				rdy = rv;
			end
		endcase
		mx    = gx;
		my    = gy;
		stepx = (rdx >= 0) ? 1 : -1;
		stepy = (rdy >= 0) ? 1 : -1;
		ax    = (rdx < 0) ? -rdx : rdx;
		ay    = (rdy < 0) ? -rdy : rdy;
		// boundary accumulators, cross-multiplied so no divide is needed
		if (ax == 0) begin
			sx  = 32'h7FFF_FFFF;
			dxs = 0;
		end else begin
			sx  = ((rdx > 0) ? CELL_ONE - CELL_HALF : CELL_HALF) * ay;
			dxs = CELL_ONE * ay;
		end
		if (ay == 0) begin
			sy  = 32'h7FFF_FFFF;
			dys = 0;
		end else begin
			sy  = ((rdy > 0) ? CELL_ONE - CELL_HALF : CELL_HALF) * ax;
			dys = CELL_ONE * ax;
		end
		// walk until a wall; off-grid cells are walls, ties step along y
		side = 1'b0;
		for (int steps = 0; steps < GUARD_MAX; steps++) begin
			if (mx < 0 || my < 0 || mx >= GRID_SIZE || my >= GRID_SIZE)
				break;
			if (map[my * 8 + mx])
				break;
			if (sx < sy) begin
				sx   += dxs;
				mx   += stepx;
				side  = 1'b0;
			end else begin
				sy   += dys;
				my   += stepy;
				side  = 1'b1;
			end
		end
		// perpendicular distance and height, truncating divide
		if (!side) begin
			perp_dist = (stepx > 0) ? mx * CELL_ONE - px : px - (mx + 1) * CELL_ONE;
			h = (perp_dist > 0 && ax > 0) ? (SCREEN_HEIGHT * ax) / perp_dist : SCREEN_HEIGHT;
		end else begin
			perp_dist = (stepy > 0) ? my * CELL_ONE - py : py - (my + 1) * CELL_ONE;
			h = (perp_dist > 0 && ay > 0) ? (SCREEN_HEIGHT * ay) / perp_dist : SCREEN_HEIGHT;
		end
		if (h > SCREEN_HEIGHT)
			h = SCREEN_HEIGHT;
		top = SCREEN_HEIGHT / 2 - h / 2;
		bot = SCREEN_HEIGHT / 2 + h / 2;
		if (top < 0)
			top = 0;
		if (bot > SCREEN_HEIGHT)
			bot = SCREEN_HEIGHT;
		span.column_echo = 7'(col);
		span.top_row     = 7'(top);
		span.wall_bottom = 8'(bot);
		span.hit_side    = side;
		return span;
	endfunction

	// offer one item, record its span once accepted, return at a falling edge
	task automatic send_column(input req_t item, input bit typed, input rsp_t want);
		while ($urandom_range(99) < send_idle_pct) begin
			req_valid <= 1'b0;
			@(negedge clk);
		end
		req_valid <= 1'b1;
		req       <= item;
		do
			@(posedge clk);
		while (req_stall);
		expected_spans.push_back(typed ? want : cast_column(item, wall_map_now));
		items_sent++;
		@(negedge clk);
	endtask

	// random items, mostly from open cells so the walk goes somewhere
	task automatic send_random(input int count);
		req_t item;
		int   tries;
		repeat (count) begin
			item.cell_x = 3'($urandom);
			item.cell_y = 3'($urandom);
			item.facing = 2'($urandom);
			if ($urandom_range(99) < 85)
				item.screen_column = 7'($urandom_range(COLUMN_COUNT - 1));
			else
				item.screen_column = 7'($urandom_range(127));
			tries = 0;
			while (tries < 16 && wall_map_now[{item.cell_y, item.cell_x}]
				&& $urandom_range(9) != 0) begin
				item.cell_x = 3'($urandom);
				item.cell_y = 3'($urandom);
				tries++;
			end
			send_column(item, 1'b0, '0);
		end
	endtask

	// drop valid and wait for every outstanding span
	task automatic drain();
		req_valid <= 1'b0;
		do
			@(negedge clk);
		while (expected_spans.size() != 0);
	endtask

	// new wall map while idle, then a batch of random items
	task automatic run_phase(input logic [MAP_W-1:0] map, input int count);
		drain();
		cfg_we    <= 1'b1;
		cfg_wdata <= map;
		@(negedge clk);
		cfg_we       <= 1'b0;
		wall_map_now  = map;
		map_count++;
		send_random(count);
	endtask

	// output side: random stall, or a long hold-off on request
	initial begin : rsp_side
		int stall_left;
		stall_left = 0;
		forever begin
			@(negedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				stall_left   = HOLD_CYCLES;
			end
			if (stall_left > 0) begin
				stall_left--;
				rsp_stall <= 1'b1;
			end else begin
				rsp_stall <= ($urandom_range(99) < recv_idle_pct);
			end
		end
	end

	// span checker
	always @(posedge clk) begin : span_check
		rsp_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (expected_spans.size() == 0) begin
				$display("%0t unexpected span for column %0d", $time, rsp.column_echo);
				mismatches++;
			end else begin
				want = expected_spans.pop_front();
				spans_checked++;
				if (rsp.column_echo !== want.column_echo) begin
					$display("%0t column_echo expected %0d got %0d",
						$time, want.column_echo, rsp.column_echo);
					mismatches++;
				end
				if (rsp.top_row !== want.top_row) begin
					$display("%0t column %0d top_row expected %0d got %0d",
						$time, want.column_echo, want.top_row, rsp.top_row);
					mismatches++;
				end
				if (rsp.wall_bottom !== want.wall_bottom) begin
					$display("%0t column %0d wall_bottom expected %0d got %0d",
						$time, want.column_echo, want.wall_bottom, rsp.wall_bottom);
					mismatches++;
				end
				if (rsp.hit_side !== want.hit_side) begin
					$display("%0t column %0d hit_side expected %0d got %0d",
						$time, want.column_echo, want.hit_side, rsp.hit_side);
					mismatches++;
				end
			end
		end
	end

	// watchdog
	initial begin : watchdog
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("run stopped at the cycle limit with %0d spans outstanding",
			expected_spans.size());
		$display("FAILURE");
		$finish;
	end

	// stimulus
	initial begin : stimulus
		probe_row_t probes [PROBE_COUNT];
		arst_n        = 1'b0;
		req_valid     = 1'b0;
		req           = '0;
		rsp_stall     = 1'b0;
		cfg_we        = 1'b0;
		cfg_wdata     = '0;
		hold_request  = 1'b0;
		mismatches    = 0;
		items_sent    = 0;
		spans_checked = 0;
		send_idle_pct = 27;
		recv_idle_pct = 57;
		wall_map_now  = WALL_MAP_RESET;
		map_count     = 1;

		// player in a wall cell gives a full-height span on the vertical side
		probes = '{
			'{'{3'd0, 3'd0, FACE_NORTH, 7'd0},   1'b1, '{7'd0,   7'd0, 8'd200, 1'b0}},
			'{'{3'd7, 3'd7, FACE_EAST,  7'd127}, 1'b1, '{7'd127, 7'd0, 8'd200, 1'b0}},
			'{'{3'd2, 3'd2, FACE_SOUTH, 7'd79},  1'b1, '{7'd79,  7'd0, 8'd200, 1'b0}},
			'{'{3'd3, 3'd2, FACE_WEST,  7'd40},  1'b1, '{7'd40,  7'd0, 8'd200, 1'b0}},
			'{'{3'd1, 3'd1, FACE_NORTH, 7'd0},   1'b0, '0},
			'{'{3'd1, 3'd1, FACE_EAST,  7'd40},  1'b0, '0},
			'{'{3'd1, 3'd1, FACE_SOUTH, 7'd79},  1'b0, '0},
			'{'{3'd1, 3'd1, FACE_WEST,  7'd127}, 1'b0, '0},
			// center column: one ray component is zero
			'{'{3'd6, 3'd6, FACE_NORTH, 7'd40},  1'b0, '0},
			'{'{3'd6, 3'd6, FACE_EAST,  7'd40},  1'b0, '0},
			'{'{3'd6, 3'd6, FACE_SOUTH, 7'd40},  1'b0, '0},
			'{'{3'd6, 3'd6, FACE_WEST,  7'd40},  1'b0, '0},
			'{'{3'd4, 3'd3, FACE_NORTH, 7'd20},  1'b0, '0},
			'{'{3'd3, 3'd4, FACE_EAST,  7'd60},  1'b0, '0},
			'{'{3'd6, 3'd1, FACE_SOUTH, 7'd1},   1'b0, '0},
			'{'{3'd1, 3'd6, FACE_WEST,  7'd78},  1'b0, '0},
			// two columns past the screen edge, then two inside it
			'{'{3'd4, 3'd5, FACE_NORTH, 7'd80},  1'b0, '0},
			'{'{3'd1, 3'd4, FACE_EAST,  7'd100}, 1'b0, '0},
			'{'{3'd3, 3'd6, FACE_SOUTH, 7'd64},  1'b0, '0},
			'{'{3'd6, 3'd3, FACE_WEST,  7'd5},   1'b0, '0}
		};

		repeat (3) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed rows on the reset map
		foreach (probes[i])
			send_column(probes[i].stim, probes[i].typed, probes[i].want);

		// long output hold-off while items keep coming
		hold_request = 1'b1;
		send_random(6);

		// receiver idles more than sender
		run_phase('0, 70);
		run_phase('1, 15);

		// sender idles more than receiver
		send_idle_pct = 57;
		recv_idle_pct = 27;
		run_phase({$urandom, $urandom} & {$urandom, $urandom}, 90);
		run_phase(WALL_MAP_RESET, 90);

		// no idling
		send_idle_pct = 0;
		recv_idle_pct = 0;
		run_phase({$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom}, 90);
		run_phase({$urandom, $urandom}, 75);

		drain();
		repeat (SETTLE_WAIT) @(negedge clk);
		if (expected_spans.size() != 0) begin
			$display("%0t %0d spans never arrived", $time, expected_spans.size());
			mismatches++;
		end

		$display("%0d column rays cast over %0d wall maps, %0d spans checked, %0d cycles",
			items_sent, map_count, spans_checked, cycle_count);
		$display("directed edge rows, a long output hold-off and three idling mixes");
		if (mismatches == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

// File: files.f
hdl/gdr_pkg.sv
hdl/gdr_walk.sv
hdl/gdr_div.sv
hdl/grid_dda_raycast_column.sv
tb/sv/grid_dda_raycast_column_tb.sv
